@@ design/rain_particle_fall_project_core_defines.svh @@
// Assertion macros shared by the rain particle core.
// Uses clk_i and rst_ni of the including module; no other dependencies.
`ifndef RAIN_PARTICLE_FALL_PROJECT_CORE_DEFINES_SVH
`define RAIN_PARTICLE_FALL_PROJECT_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RPFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define RPFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rpfp_pkg.sv @@
// Package of the rain particle core: screen constants, codes, widths and helpers.
// Used by rpfp_div and rain_particle_fall_project_core.
package rpfp_pkg;

  localparam int SCREEN_HALF_WIDTH  = 80;
  localparam int SCREEN_HALF_HEIGHT = 64;

  localparam longint OFS_X = longint'(SCREEN_HALF_WIDTH) * 65536;
  localparam longint OFS_Y = longint'(SCREEN_HALF_HEIGHT) * 65536;
  localparam longint OFS_D = 65536;

  localparam int KMAX = ((SCREEN_HALF_WIDTH > SCREEN_HALF_HEIGHT) ?
                         SCREEN_HALF_WIDTH : SCREEN_HALF_HEIGHT) * 65536;
  localparam int KW = $clog2(KMAX + 1);

  // Dividend magnitude width: |r| is at most 2^31, times the scale factor.
  localparam int DIV_NW  = 32 + KW;
  localparam int DIV_LAT = DIV_NW + 1;

  localparam int IN_DW  = 152;
  localparam int OUT_DW = 240;

  localparam logic signed [31:0] FLOOR_Y_RST     = 32'sd0;
  localparam logic [30:0]        FALL_SPEED_RST  = 31'd6554;
  localparam logic [30:0]        LINE_LENGTH_RST = 31'd131072;
  localparam logic [7:0]         LINE_COLOR_RST  = 8'd15;

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_PARTICLE = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_FLOOR_Y     = 2'd0,
    CFG_FALL_SPEED  = 2'd1,
    CFG_LINE_LENGTH = 2'd2,
    CFG_LINE_COLOR  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic               v;
    logic               retired;
    logic               fault;
    logic signed [31:0] ny;
  } side_t;

  typedef struct packed {
    logic               retired;
    logic signed [31:0] new_y;
    logic               drawn;
    logic               fault;
    logic signed [31:0] head_x;
    logic signed [31:0] head_y;
    logic signed [31:0] head_depth;
    logic signed [31:0] tail_x;
    logic signed [31:0] tail_y;
    logic signed [31:0] tail_depth;
    logic [7:0]         color;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ design/rpfp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, then a sign stage.
// Depends on rpfp_pkg for DIV_NW.
module rpfp_div (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [rpfp_pkg::DIV_NW-1:0]        num_i,
  input  logic [31:0]                        den_i,
  input  logic                               neg_i,
  output logic signed [rpfp_pkg::DIV_NW:0]   q_o
);
  import rpfp_pkg::*;

  logic [DIV_NW-1:0] num_q [DIV_NW];
  logic              neg_q [DIV_NW];
  logic [31:0]       rem_q [DIV_NW-1];
  logic [31:0]       den_q [DIV_NW-1];
  logic signed [DIV_NW:0] q_q;

  for (genvar s = 0; s < DIV_NW; s++) begin : g_stage
    logic [DIV_NW-1:0] num_in;
    logic [31:0]       rem_in;
    logic [31:0]       den_in;
    logic              neg_in;
    logic [32:0]       cand;
    logic              ge;

    if (s == 0) begin : g_first
      assign num_in = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
      assign neg_in = neg_i;
    end else begin : g_next
      assign num_in = num_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign neg_in = neg_q[s-1];
    end

    assign cand = {rem_in, num_in[DIV_NW-1]};
    assign ge   = (cand >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s] <= {num_in[DIV_NW-2:0], ge};
        neg_q[s] <= neg_in;
      end
    end

    if (s < DIV_NW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= ge ? 32'(cand - {1'b0, den_in}) : cand[31:0];
          den_q[s] <= den_in;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= neg_q[DIV_NW-1] ? -$signed({1'b0, num_q[DIV_NW-1]})
                             : $signed({1'b0, num_q[DIV_NW-1]});
    end
  end

  assign q_o = q_q;

endmodule

@@ design/rain_particle_fall_project_core.sv @@
// Top level of the rain particle fall and perspective projection core.
// Depends on rpfp_pkg, rpfp_div and rain_particle_fall_project_core_defines.svh.
`include "rain_particle_fall_project_core_defines.svh"

// The core takes one request per cycle while s_axis_tready is high; most of the
// pipeline depth comes from the six dividers that resolve one quotient bit per
// stage. A load request writes one camera matrix word and yields no result. A
// particle request yields one result. Configuration writes are taken in any cycle and
// must only be issued while the core is idle. A stall on the result side holds the
// whole pipe while the last divider stage holds a valid entry.
module rain_particle_fall_project_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [3:0] matrix_index, [35:4] matrix_value, [67:36] pos_x, [99:68] pos_y,
  // [131:100] pos_z, [147:132] elapsed_ms, [151:148] zero
  input  logic [rpfp_pkg::IN_DW-1:0]     s_axis_tdata,
  // [0] opcode
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [31:0] new_y, [32] drawn, [33] divide_fault, [65:34] head_x,
  // [97:66] head_y, [129:98] head_depth, [161:130] tail_x, [193:162] tail_y,
  // [225:194] tail_depth, [233:226] color, [239:234] zero
  output logic [rpfp_pkg::OUT_DW-1:0]    m_axis_tdata,
  // [0] retired
  output logic [0:0]                     m_axis_tuser,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);
  import rpfp_pkg::*;

  localparam logic [KW-1:0] KX_U = KW'(OFS_X);
  localparam logic [KW-1:0] KY_U = KW'(OFS_Y);
  localparam logic [KW-1:0] KD_U = KW'(OFS_D);

  logic signed [31:0] floor_y_q;
  logic [30:0]        fall_speed_q;
  logic [30:0]        line_length_q;
  logic [7:0]         line_color_q;

  logic en;
  logic out_free;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q;

  opcode_e            s1_op_q, s2_op_q, s3_op_q, s4_op_q;
  logic [3:0]         s1_idx_q, s2_idx_q, s3_idx_q, s4_idx_q;
  logic signed [31:0] s1_val_q, s2_val_q, s3_val_q, s4_val_q;
  logic signed [31:0] s1_x_q, s2_x_q, s3_x_q, s4_x_q;
  logic signed [31:0] s1_y_q, s2_y_q;
  logic signed [31:0] s1_z_q, s2_z_q, s3_z_q, s4_z_q;
  logic [15:0]        s1_ms_q;
  logic [46:0]        s2_prod_q;
  logic signed [31:0] s3_ny_q, s4_ny_q, s5_ny_q, s6_ny_q, s7_ny_q, s8_ny_q, s9_ny_q;
  logic signed [31:0] s4_ty_q;
  logic               s4_ret_q, s5_ret_q, s6_ret_q, s7_ret_q, s8_ret_q, s9_ret_q;
  logic               s8_fault_q, s9_fault_q;

  logic signed [31:0] mat_q [4][4];

  logic signed [47:0] px_q  [4];
  logic signed [47:0] pz_q  [4];
  logic signed [47:0] phy_q [4];
  logic signed [47:0] pty_q [4];
  logic signed [31:0] m3_q  [4];
  logic signed [48:0] ha_q  [4];
  logic signed [48:0] ta_q  [4];
  logic signed [48:0] b_q   [4];
  logic signed [31:0] rh_q  [4];
  logic signed [31:0] rt_q  [4];

  logic [31:0]        absn_q [6];
  logic [31:0]        absd_q [6];
  logic               neg8_q [6];
  logic [DIV_NW-1:0]  num_q  [6];
  logic [31:0]        den_q  [6];
  logic               neg9_q [6];
  logic signed [DIV_NW:0] q_w [6];

  side_t   side_q [DIV_LAT];
  side_t   side_last;
  result_t res_d, res_q;
  logic    out_v_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_y_q     <= FLOOR_Y_RST;
      fall_speed_q  <= FALL_SPEED_RST;
      line_length_q <= LINE_LENGTH_RST;
      line_color_q  <= LINE_COLOR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_FLOOR_Y:     floor_y_q     <= cfg_data_i;
        CFG_FALL_SPEED:  fall_speed_q  <= cfg_data_i[30:0];
        CFG_LINE_LENGTH: line_length_q <= cfg_data_i[30:0];
        CFG_LINE_COLOR:  line_color_q  <= cfg_data_i[7:0];
        default:         floor_y_q     <= floor_y_q;
      endcase
    end
  end

  assign side_last     = side_q[DIV_LAT-1];
  assign out_free      = !out_v_q || m_axis_tready;
  assign en            = out_free || !side_last.v;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q && (s4_op_q == OP_PARTICLE);
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q  <= opcode_e'(s_axis_tuser[0]);
      s1_idx_q <= s_axis_tdata[3:0];
      s1_val_q <= s_axis_tdata[35:4];
      s1_x_q   <= s_axis_tdata[67:36];
      s1_y_q   <= s_axis_tdata[99:68];
      s1_z_q   <= s_axis_tdata[131:100];
      s1_ms_q  <= s_axis_tdata[147:132];

      s2_op_q   <= s1_op_q;
      s2_idx_q  <= s1_idx_q;
      s2_val_q  <= s1_val_q;
      s2_x_q    <= s1_x_q;
      s2_y_q    <= s1_y_q;
      s2_z_q    <= s1_z_q;
      s2_prod_q <= 47'(fall_speed_q) * 47'(s1_ms_q);

      s3_op_q  <= s2_op_q;
      s3_idx_q <= s2_idx_q;
      s3_val_q <= s2_val_q;
      s3_x_q   <= s2_x_q;
      s3_z_q   <= s2_z_q;
      s3_ny_q  <= sat32(64'(s2_y_q) - 64'(s2_prod_q));

      s4_op_q  <= s3_op_q;
      s4_idx_q <= s3_idx_q;
      s4_val_q <= s3_val_q;
      s4_x_q   <= s3_x_q;
      s4_z_q   <= s3_z_q;
      s4_ny_q  <= s3_ny_q;
      s4_ty_q  <= sat32(64'(s3_ny_q) - 64'(line_length_q));
      s4_ret_q <= (s3_ny_q < floor_y_q);

      s5_ny_q  <= s4_ny_q;
      s5_ret_q <= s4_ret_q;
      s6_ny_q  <= s5_ny_q;
      s6_ret_q <= s5_ret_q;
      s7_ny_q  <= s6_ny_q;
      s7_ret_q <= s6_ret_q;

      s8_ny_q    <= s7_ny_q;
      s8_ret_q   <= s7_ret_q;
      s8_fault_q <= (rh_q[3] == 32'sd0) || (rt_q[3] == 32'sd0);

      s9_ny_q    <= s8_ny_q;
      s9_ret_q   <= s8_ret_q;
      s9_fault_q <= s8_fault_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k < 4; k++) begin
          mat_q[c][k] <= '0;
        end
      end
    end else if (en && v4_q && (s4_op_q == OP_LOAD)) begin
      mat_q[s4_idx_q[3:2]][s4_idx_q[1:0]] <= s4_val_q;
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_col
    logic signed [63:0] prod_x, prod_z, prod_hy, prod_ty;

    assign prod_x  = s4_x_q  * mat_q[c][0];
    assign prod_hy = s4_ny_q * mat_q[c][1];
    assign prod_ty = s4_ty_q * mat_q[c][1];
    assign prod_z  = s4_z_q  * mat_q[c][2];

    always_ff @(posedge clk_i) begin
      if (en) begin
        px_q[c]  <= prod_x[63:16];
        phy_q[c] <= prod_hy[63:16];
        pty_q[c] <= prod_ty[63:16];
        pz_q[c]  <= prod_z[63:16];
        m3_q[c]  <= mat_q[c][3];

        ha_q[c] <= 49'(px_q[c]) + 49'(phy_q[c]);
        ta_q[c] <= 49'(px_q[c]) + 49'(pty_q[c]);
        b_q[c]  <= 49'(pz_q[c]) + 49'(m3_q[c]);

        rh_q[c] <= sat32(64'(ha_q[c]) + 64'(b_q[c]));
        rt_q[c] <= sat32(64'(ta_q[c]) + 64'(b_q[c]));
      end
    end
  end

  for (genvar d = 0; d < 6; d++) begin : g_div
    localparam int AX = d % 3;
    localparam logic [KW-1:0] KSEL = (AX == 0) ? KX_U : ((AX == 1) ? KY_U : KD_U);
    logic signed [31:0] src;
    logic signed [31:0] wdiv;

    if (d < 3) begin : g_head
      assign src  = rh_q[AX];
      assign wdiv = rh_q[3];
    end else begin : g_tail
      assign src  = rt_q[AX];
      assign wdiv = rt_q[3];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        absn_q[d] <= src[31]  ? 32'(-src)  : 32'(src);
        absd_q[d] <= wdiv[31] ? 32'(-wdiv) : 32'(wdiv);
        neg8_q[d] <= src[31] ^ wdiv[31];

        num_q[d]  <= DIV_NW'(absn_q[d]) * DIV_NW'(KSEL);
        den_q[d]  <= absd_q[d];
        neg9_q[d] <= neg8_q[d];
      end
    end

    rpfp_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[d]),
      .den_i (den_q[d]),
      .neg_i (neg9_q[d]),
      .q_o   (q_w[d])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        side_q[i] <= '0;
      end
    end else if (en) begin
      side_q[0] <= '{v: v9_q, retired: s9_ret_q, fault: s9_fault_q, ny: s9_ny_q};
      for (int i = 1; i < DIV_LAT; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  always_comb begin
    logic signed [31:0] hx, hy, hd, tx, ty, td;
    hx = sat32(OFS_X + 64'(q_w[0]));
    hy = sat32(OFS_Y - 64'(q_w[1]));
    hd = sat32(64'(q_w[2]));
    tx = sat32(OFS_X + 64'(q_w[3]));
    ty = sat32(OFS_Y - 64'(q_w[4]));
    td = sat32(64'(q_w[5]));
    res_d = '0;
    res_d.new_y   = side_last.ny;
    res_d.retired = side_last.retired;
    if (!side_last.retired) begin
      res_d.color = line_color_q;
      if (side_last.fault) begin
        res_d.fault = 1'b1;
      end else begin
        res_d.drawn      = (hd > 32'sd0);
        res_d.head_x     = hx;
        res_d.head_y     = hy;
        res_d.head_depth = hd;
        res_d.tail_x     = tx;
        res_d.tail_y     = ty;
        res_d.tail_depth = td;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= side_last.v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = res_q.retired;
  assign m_axis_tdata  = {6'd0, res_q.color, res_q.tail_depth, res_q.tail_y, res_q.tail_x,
                          res_q.head_depth, res_q.head_y, res_q.head_x,
                          res_q.fault, res_q.drawn, res_q.new_y};

  `RPFP_ASSERT_IMP(a_retired_quiet, out_v_q && res_q.retired,
                   !res_q.drawn && !res_q.fault && (res_q.color == 8'd0),
                   "retired particle reports a streak")
  `RPFP_ASSERT_IMP(a_fault_blank, out_v_q && res_q.fault,
                   !res_q.drawn && (res_q.head_x == 32'sd0) && (res_q.tail_x == 32'sd0),
                   "zero w result carries coordinates")
  `RPFP_ASSERT_IMP(a_drawn_depth, out_v_q && res_q.drawn,
                   res_q.head_depth > 32'sd0,
                   "streak drawn with non-positive head depth")
  `RPFP_ASSERT_NXT(a_stall_holds, !en,
                   $stable(side_q[DIV_LAT-1]),
                   "last divider stage moved during a stall")

endmodule
